// ===== sv/mrpm_pkg.sv =====
// shared types, constants and crc function for the modbus read poll master
`default_nettype none

package mrpm_pkg;

  localparam int unsigned CFG_ADDR_W   = 5;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_STATION    = 3'd0;
  localparam logic [2:0] REG_FUNCTION   = 3'd1;
  localparam logic [2:0] REG_START      = 3'd2;
  localparam logic [2:0] REG_COUNT      = 3'd3;
  localparam logic [2:0] REG_BYTE_COUNT = 3'd4;

  // register reset values
  localparam logic [7:0]  RST_STATION    = 8'h0A;
  localparam logic [7:0]  RST_FUNCTION   = 8'h04;
  localparam logic [15:0] RST_START      = 16'h0000;
  localparam logic [15:0] RST_COUNT      = 16'h0002;
  localparam logic [7:0]  RST_BYTE_COUNT = 8'h04;

  // input and result kinds
  localparam logic REQ_POLL    = 1'b0;
  localparam logic REQ_RX_BYTE = 1'b1;
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // frame byte positions
  localparam logic [2:0] POS_STATION = 3'd0;
  localparam logic [2:0] POS_FUNC    = 3'd1;
  localparam logic [2:0] POS_START_H = 3'd2;
  localparam logic [2:0] POS_START_L = 3'd3;
  localparam logic [2:0] POS_COUNT_H = 3'd4;
  localparam logic [2:0] POS_COUNT_L = 3'd5;
  localparam logic [2:0] POS_CRC_L   = 3'd6;
  localparam logic [2:0] POS_CRC_H   = 3'd7;

  typedef struct packed {
    logic [7:0]  station;
    logic [7:0]  func;
    logic [15:0] start_reg;
    logic [15:0] reg_count;
    logic [7:0]  byte_count;
  } cfg_t;

  // one queued command for the back end
  typedef struct packed {
    logic        kind;
    logic [31:0] reading;
  } cmd_t;

  // one crc-16/modbus byte update, eight shift steps
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mrpm_if.sv =====
// item channel interfaces for poll/rx input and result output
`default_nettype none

interface mrpm_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mrpm_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [31:0] reading;
  logic        last;

  modport source (output valid, output out_kind, output tx_byte, output reading,
                  output last, input ready);
  modport sink (input valid, input out_kind, input tx_byte, input reading,
                input last, output ready);
endinterface

`default_nettype wire

// ===== sv/mrpm_cfg.sv =====
// apb register block holding station, function, start, count and byte count
`default_nettype none

module mrpm_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mrpm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mrpm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [mrpm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output mrpm_pkg::cfg_t                          cfg
);

  mrpm_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station    <= mrpm_pkg::RST_STATION;
      cfg_r.func       <= mrpm_pkg::RST_FUNCTION;
      cfg_r.start_reg  <= mrpm_pkg::RST_START;
      cfg_r.reg_count  <= mrpm_pkg::RST_COUNT;
      cfg_r.byte_count <= mrpm_pkg::RST_BYTE_COUNT;
    end else if (wr_en) begin
      case (reg_idx)
        mrpm_pkg::REG_STATION:    cfg_r.station    <= pwdata[7:0];
        mrpm_pkg::REG_FUNCTION:   cfg_r.func       <= pwdata[7:0];
        mrpm_pkg::REG_START:      cfg_r.start_reg  <= pwdata[15:0];
        mrpm_pkg::REG_COUNT:      cfg_r.reg_count  <= pwdata[15:0];
        mrpm_pkg::REG_BYTE_COUNT: cfg_r.byte_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      mrpm_pkg::REG_STATION:    prdata = {24'h0, cfg_r.station};
      mrpm_pkg::REG_FUNCTION:   prdata = {24'h0, cfg_r.func};
      mrpm_pkg::REG_START:      prdata = {16'h0, cfg_r.start_reg};
      mrpm_pkg::REG_COUNT:      prdata = {16'h0, cfg_r.reg_count};
      mrpm_pkg::REG_BYTE_COUNT: prdata = {24'h0, cfg_r.byte_count};
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/mrpm_front.sv =====
// front end: accepts items, runs the response recognizer, queues commands
`default_nettype none

module mrpm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrpm_pkg::cfg_t  cfg,
  mrpm_in_if.sink              in_ch,
  input  wire logic            q_full,
  output logic                 q_push,
  output mrpm_pkg::cmd_t       q_cmd
);

  typedef enum logic [8:0] {
    RX_WAIT  = 9'b000000001,
    RX_FUNC  = 9'b000000010,
    RX_COUNT = 9'b000000100,
    RX_D0    = 9'b000001000,
    RX_D1    = 9'b000010000,
    RX_D2    = 9'b000100000,
    RX_D3    = 9'b001000000,
    RX_CRC0  = 9'b010000000,
    RX_CRC1  = 9'b100000000
  } rx_state_t;

  rx_state_t   rx_state_r, rx_state_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        accept;
  logic        is_rx;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;
  assign is_rx       = (in_ch.req_type == mrpm_pkg::REQ_RX_BYTE);

  // recognizer next state
  always_comb begin
    rx_state_nxt = rx_state_r;
    accum_nxt    = accum_r;
    if (accept && is_rx) begin
      case (rx_state_r)
        RX_FUNC:  rx_state_nxt = (in_ch.rx_byte == cfg.func) ? RX_COUNT : RX_WAIT;
        RX_COUNT: rx_state_nxt = (in_ch.rx_byte == cfg.byte_count) ? RX_D0 : RX_WAIT;
        RX_D0, RX_D1, RX_D2, RX_D3: begin
          accum_nxt = {accum_r[23:0], in_ch.rx_byte};
          case (rx_state_r)
            RX_D0:   rx_state_nxt = RX_D1;
            RX_D1:   rx_state_nxt = RX_D2;
            RX_D2:   rx_state_nxt = RX_D3;
            default: rx_state_nxt = RX_CRC0;
          endcase
        end
        RX_CRC0:  rx_state_nxt = RX_CRC1;
        RX_CRC1:  rx_state_nxt = RX_WAIT;
        default:  rx_state_nxt = (in_ch.rx_byte == cfg.station) ? RX_FUNC : RX_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r <= RX_WAIT;
      accum_r    <= '0;
    end else begin
      rx_state_r <= rx_state_nxt;
      accum_r    <= accum_nxt;
    end
  end

  // queue a poll, or a reading when the last crc byte arrives
  assign q_push = accept & (~is_rx | (rx_state_r == RX_CRC1));
  always_comb begin
    q_cmd.kind    = is_rx ? mrpm_pkg::KIND_READ : mrpm_pkg::KIND_TX;
    q_cmd.reading = is_rx ? accum_r : 32'h0;
  end

endmodule

`default_nettype wire

// ===== sv/mrpm_cmd_fifo.sv =====
// short command queue between front and back end
`default_nettype none

module mrpm_cmd_fifo #(
  parameter int unsigned DEPTH = mrpm_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mrpm_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output mrpm_pkg::cmd_t       head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  mrpm_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mrpm_back.sv =====
// back end: drains commands into request frame bytes or readings
`default_nettype none

module mrpm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrpm_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire mrpm_pkg::cmd_t  q_head,
  output logic                 q_pop,
  mrpm_out_if.source           out_ch
);

  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  tx_byte_r;
  logic [31:0] reading_r;
  logic        last_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        load;
  logic        is_read;
  logic [7:0]  frame_byte;
  logic [15:0] crc_base;

  assign load    = ~out_valid_r | out_ch.ready;
  assign is_read = (q_head.kind == mrpm_pkg::KIND_READ);
  assign q_pop   = load & ~q_empty & (is_read | (pos_r == mrpm_pkg::POS_CRC_H));

  // frame byte select
  always_comb begin
    case (pos_r)
      mrpm_pkg::POS_STATION: frame_byte = cfg.station;
      mrpm_pkg::POS_FUNC:    frame_byte = cfg.func;
      mrpm_pkg::POS_START_H: frame_byte = cfg.start_reg[15:8];
      mrpm_pkg::POS_START_L: frame_byte = cfg.start_reg[7:0];
      mrpm_pkg::POS_COUNT_H: frame_byte = cfg.reg_count[15:8];
      mrpm_pkg::POS_COUNT_L: frame_byte = cfg.reg_count[7:0];
      mrpm_pkg::POS_CRC_L:   frame_byte = crc_r[7:0];
      default:               frame_byte = crc_r[15:8];
    endcase
  end

  // running crc over the six header bytes
  assign crc_base = (pos_r == mrpm_pkg::POS_STATION) ? mrpm_pkg::CRC_INIT : crc_r;
  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    if (load && !q_empty && !is_read) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r < mrpm_pkg::POS_CRC_L) begin
        crc_nxt = mrpm_pkg::crc_feed(crc_base, frame_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= mrpm_pkg::POS_STATION;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_kind_r <= q_head.kind;
      tx_byte_r  <= is_read ? 8'h00 : frame_byte;
      reading_r  <= is_read ? q_head.reading : 32'h0;
      last_r     <= is_read | (pos_r == mrpm_pkg::POS_CRC_H);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_kind = out_kind_r;
  assign out_ch.tx_byte  = tx_byte_r;
  assign out_ch.reading  = reading_r;
  assign out_ch.last     = last_r;

endmodule

`default_nettype wire

// ===== sv/modbus_read_poll_master_top.sv =====
// top level of the modbus rtu read poll master
//
// in_ch carries items: req_type 0 asks for a poll request, req_type 1 hands
// over one received bus byte in rx_byte. out_ch returns results: out_kind 0
// is one request frame byte in tx_byte, out_kind 1 a completed 32-bit reading;
// last marks the final result of an item. A poll gives eight bytes (station,
// function, start, count, crc low, crc high); the ninth byte of a matching
// response gives one reading, any other byte gives nothing.
// The front end takes one item per cycle while the command queue has room
// and runs the response recognizer in that same cycle. The back end sends
// one result per cycle from a registered output stage fed by the queue: a poll
// occupies it for eight results, a reading for one. The crc is built one byte
// per cycle as bytes leave. When out_ch stalls, the output stage holds and
// the queue fills; in_ch.ready drops only once the queue is full. Reset brings
// registers to their defaults, empties the queue and returns the recognizer
// to waiting for the station. Registers are to be written over the apb port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module modbus_read_poll_master_top #(
  parameter int unsigned FIFO_DEPTH = mrpm_pkg::FIFO_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  mrpm_in_if.sink                               in_ch,
  mrpm_out_if.source                            out_ch,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mrpm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [mrpm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [mrpm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  mrpm_pkg::cfg_t cfg;
  mrpm_pkg::cmd_t push_cmd;
  mrpm_pkg::cmd_t head;
  logic           push, pop, full, empty;

  mrpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mrpm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  mrpm_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  mrpm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (empty),
    .q_head  (head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/modbus_read_poll_master_top_tb.sv =====
// testbench for the modbus read poll master: frames and readings checked by a local predictor
`default_nettype none

module modbus_read_poll_master_top_tb;

  localparam int STALL_LIMIT = 2000;

  // one result as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [31:0] reading;
    logic        last;
  } poll_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mrpm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mrpm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mrpm_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  mrpm_in_if  in_ch ();
  mrpm_out_if out_ch ();

  modbus_read_poll_master_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor copy of the registers and recognizer state
  mrpm_pkg::cfg_t regs;
  logic [3:0]     rx_pos;
  logic [31:0]    data_shift;
  poll_result_t   outbound_q [$];

  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles;
  int idle_cycles;
  int error_count;
  int items_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request frame: six header bytes plus crc-16/modbus, low byte first
  function automatic void queue_request_frame();
    logic [7:0]   frame [8];
    logic [15:0]  crc;
    logic         fb;
    poll_result_t r;
    frame = '{regs.station, regs.func, regs.start_reg[15:8], regs.start_reg[7:0],
              regs.reg_count[15:8], regs.reg_count[7:0], 8'h00, 8'h00};
    crc = mrpm_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 8; j++) begin
        fb  = crc[0] ^ frame[i][j];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ mrpm_pkg::CRC_POLY;
        end
      end
    end
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    for (int k = 0; k < 8; k++) begin
      r.kind    = mrpm_pkg::KIND_TX;
      r.tx_byte = frame[k];
      r.reading = 32'h0;
      r.last    = (k == 7);
      outbound_q.push_back(r);
    end
  endfunction

  // response recognizer: 0 waits for station, 1..2 header, 3..6 data, 7..8 crc
  function automatic void recognize_rx_byte(logic [7:0] b);
    poll_result_t r;
    case (rx_pos)
      4'd1: begin
        rx_pos = (b == regs.func) ? 4'd2 : 4'd0;
      end
      4'd2: begin
        rx_pos = (b == regs.byte_count) ? 4'd3 : 4'd0;
      end
      4'd3, 4'd4, 4'd5, 4'd6: begin
        data_shift = {data_shift[23:0], b};
        rx_pos     = rx_pos + 4'd1;
      end
      4'd7: begin
        rx_pos = 4'd8;
      end
      4'd8: begin
        rx_pos    = 4'd0;
        r.kind    = mrpm_pkg::KIND_READ;
        r.tx_byte = 8'h00;
        r.reading = data_shift;
        r.last    = 1'b1;
        outbound_q.push_back(r);
      end
      default: begin
        rx_pos = (b == regs.station) ? 4'd1 : 4'd0;
      end
    endcase
  endfunction

  // receiver side: random stalls, or a counted long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each result with the oldest one predicted
  always @(posedge clk) begin
    poll_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outbound_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0h tx %h reading %h last %0h",
                 $time, out_ch.out_kind, out_ch.tx_byte, out_ch.reading, out_ch.last);
        error_count++;
      end else begin
        want = outbound_q.pop_front();
        check_field("out_kind", {31'h0, want.kind}, {31'h0, out_ch.out_kind});
        check_field("tx_byte", {24'h0, want.tx_byte}, {24'h0, out_ch.tx_byte});
        check_field("reading", want.reading, out_ch.reading);
        check_field("last", {31'h0, want.last}, {31'h0, out_ch.last});
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("modbus_read_poll_master_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item on the input channel; entered and left at a falling edge
  task automatic send_item(logic rt, logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rt;
    in_ch.rx_byte  <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (rt == mrpm_pkg::REQ_POLL) begin
      queue_request_frame();
    end else begin
      recognize_rx_byte(b);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_poll();
    send_item(mrpm_pkg::REQ_POLL, 8'($urandom_range(255)));
  endtask

  // response bytes for the current registers; a wrong header byte ends the sequence
  task automatic send_response(logic [31:0] data, int bad_at, int cut_at, int poll_at);
    logic [7:0] rx_frame [9];
    rx_frame = '{regs.station, regs.func, regs.byte_count, data[31:24], data[23:16],
                 data[15:8], data[7:0], 8'($urandom_range(255)), 8'($urandom_range(255))};
    if (bad_at == 1 || bad_at == 2) begin
      rx_frame[bad_at] = rx_frame[bad_at] ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < 9 && k < cut_at; k++) begin
      if (k == poll_at) begin
        send_poll();
      end
      send_item(mrpm_pkg::REQ_RX_BYTE, rx_frame[k]);
      if (k == bad_at) begin
        break;
      end
    end
  endtask

  // apb write, then read back the same register
  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    logic [31:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      mrpm_pkg::REG_STATION: begin
        regs.station = value[7:0];
        held = {24'h0, value[7:0]};
      end
      mrpm_pkg::REG_FUNCTION: begin
        regs.func = value[7:0];
        held = {24'h0, value[7:0]};
      end
      mrpm_pkg::REG_START: begin
        regs.start_reg = value[15:0];
        held = {16'h0, value[15:0]};
      end
      mrpm_pkg::REG_COUNT: begin
        regs.reg_count = value[15:0];
        held = {16'h0, value[15:0]};
      end
      mrpm_pkg::REG_BYTE_COUNT: begin
        regs.byte_count = value[7:0];
        held = {24'h0, value[7:0]};
      end
      default: begin
        held = 32'h0;
      end
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== held) begin
      $display("%0t: readback of register %0d, expected %h actual %h", $time, idx, held, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(logic [7:0] st, logic [7:0] fn, logic [15:0] start,
                           logic [15:0] count, logic [7:0] bc);
    write_register(mrpm_pkg::REG_STATION, {24'h0, st});
    write_register(mrpm_pkg::REG_FUNCTION, {24'h0, fn});
    write_register(mrpm_pkg::REG_START, {16'h0, start});
    write_register(mrpm_pkg::REG_COUNT, {16'h0, count});
    write_register(mrpm_pkg::REG_BYTE_COUNT, {24'h0, bc});
  endtask

  // sender pauses until every predicted result has left the block
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (outbound_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_reset_poll();
    send_poll();
  endtask

  task automatic test_response_cases();
    // wrong station while waiting is ignored
    send_item(mrpm_pkg::REQ_RX_BYTE, regs.station ^ 8'h01);
    // bad function byte equal to the station is not taken as a new start
    send_item(mrpm_pkg::REQ_RX_BYTE, regs.station);
    send_item(mrpm_pkg::REQ_RX_BYTE, regs.station);
    send_item(mrpm_pkg::REQ_RX_BYTE, regs.func);
    // bad byte count
    send_response(32'h80FF007F, 2, 9, -1);
    // full response with a poll in the middle, sign bits set in data
    send_response(32'h80FF007F, -1, 9, 3);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_all(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_poll();
    wait_idle();
    write_all(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_poll();
    send_response(32'hFFFFFFFE, -1, 9, -1);
  endtask

  task automatic test_receiver_stall();
    wait_idle();
    hold_cycles = 300;
    repeat (12) send_poll();
    wait_idle();
  endtask

  // mostly well-formed responses, plus polls, broken frames and noise
  task automatic test_random_traffic(int n_items);
    int stop_at;
    int r;
    wait_idle();
    write_all(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_response($urandom, -1, 9,
                      ($urandom_range(9) == 0) ? $urandom_range(1, 8) : -1);
      end else if (r < 65) begin
        send_poll();
      end else if (r < 85) begin
        send_response($urandom, ($urandom_range(1) == 0) ? $urandom_range(1, 2) : -1,
                      $urandom_range(1, 8), -1);
      end else begin
        send_item(mrpm_pkg::REQ_RX_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_idle_pct    = 0;
    out_idle_pct   = 0;
    hold_cycles    = 0;
    idle_cycles    = 0;
    error_count    = 0;
    items_sent     = 0;
    regs           = '{mrpm_pkg::RST_STATION, mrpm_pkg::RST_FUNCTION, mrpm_pkg::RST_START,
                       mrpm_pkg::RST_COUNT, mrpm_pkg::RST_BYTE_COUNT};
    rx_pos         = 4'd0;
    data_shift     = 32'h0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_poll();
    test_response_cases();
    test_register_extremes();

    in_idle_pct  = 7;
    out_idle_pct = 65;
    test_random_traffic(130);
    test_receiver_stall();

    in_idle_pct  = 65;
    out_idle_pct = 7;
    test_random_traffic(130);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_traffic(130);

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("modbus_read_poll_master_top verification clean");
    end else begin
      $display("modbus_read_poll_master_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
